>>> hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared widths, command codes and types of the first-fit hole allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned SlotW    = 4;   // slot and chosen_slot fields
  localparam int unsigned AmtW     = 16;  // hole sizes and request sizes
  localparam int unsigned TagW     = 8;   // request tag
  localparam int unsigned CfgW     = 5;   // hole_count register
  localparam int unsigned HolesDef = 16;  // default table depth

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_e;

  // result of the shared compare/subtract unit
  typedef struct packed {
    logic            fit;
    logic [AmtW-1:0] rest;
  } fit_t;

endpackage

>>> hw/rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/ffha_fit.sv
// ----------------------------------------------------------------------------
// ffha_fit
// Shared compare/subtract unit: does the hole hold the request, and what is
// left over after taking it.
// ----------------------------------------------------------------------------
module ffha_fit (
  input  logic [ffha_pkg::AmtW-1:0] hole_i,
  input  logic [ffha_pkg::AmtW-1:0] req_i,
  output ffha_pkg::fit_t            res_o
);

  logic [ffha_pkg::AmtW:0] diff;

  // one subtract gives both: no borrow means hole >= request
  assign diff       = {1'b0, hole_i} - {1'b0, req_i};
  assign res_o.fit  = ~diff[ffha_pkg::AmtW];
  assign res_o.rest = diff[ffha_pkg::AmtW-1:0];

endmodule

>>> hw/rtl/first_fit_hole_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_hole_allocator
// First-fit allocator over a table of free-hole sizes. Loads write a hole
// size; allocations scan holes from zero and carve the request out of the
// first hole large enough.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                fields
//  in       input      in_valid_i / in_ready_o  cmd, slot, amount, tag
//  out      output     out_valid_o / out_ready_i granted, chosen_slot,
//                                               left_over, tag_out
//  cfg      input      cfg_we_i (no wait)       hole_count
//
//  A load is written to the hole table in the cycle it is accepted. An
//  allocation passes over at most min(hole_count, HOLES) holes; one hole is
//  examined per cycle through the single read port of the hole table and the
//  shared compare/subtract unit.
//  Reset clears per-hole valid bits at once; no clearing pass is needed.
//  A finished result waits in the scan state while the output register is
//  still full; the table is updated only when the result is registered.
// ----------------------------------------------------------------------------
module first_fit_hole_allocator #(
  parameter int unsigned HOLES = ffha_pkg::HolesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ffha_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [ffha_pkg::SlotW-1:0] slot_i,
  input  logic [ffha_pkg::AmtW-1:0]  amount_i,
  input  logic [ffha_pkg::TagW-1:0]  tag_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       granted_o,
  output logic [ffha_pkg::SlotW-1:0] chosen_slot_o,
  output logic [ffha_pkg::AmtW-1:0]  left_over_o,
  output logic [ffha_pkg::TagW-1:0]  tag_out_o
);

  localparam int unsigned IdxW = (HOLES > 1) ? $clog2(HOLES) : 1;
  localparam int unsigned CntW = $clog2(HOLES + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [ffha_pkg::CfgW-1:0]  hole_count_q;
  logic [CntW-1:0]            idx_q, idx_d;
  logic [CntW-1:0]            lim_q, lim_d;
  logic [ffha_pkg::AmtW-1:0]  req_q;
  logic [ffha_pkg::TagW-1:0]  tag_q;
  logic [HOLES-1:0]           valid_q;
  logic                       rd_valid_q, rd_valid_d;

  logic                       out_valid_q;
  logic                       granted_q;
  logic [ffha_pkg::SlotW-1:0] chosen_q;
  logic [ffha_pkg::AmtW-1:0]  left_q;
  logic [ffha_pkg::TagW-1:0]  tag_out_q;

  logic                       in_acc, is_alloc, load_ok;
  logic                       scan_live, hit, done, out_free, commit, advance;
  logic [CntW-1:0]            rd_cnt;
  logic [IdxW-1:0]            rd_addr, wr_addr;
  logic                       wr_en;
  logic [ffha_pkg::AmtW-1:0]  wr_data, ram_rdata, hole_val;
  ffha_pkg::fit_t             fit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_alloc   = (cmd_i == ffha_pkg::CMD_ALLOC);
  assign load_ok    = in_acc && !is_alloc && (int'(slot_i) < HOLES);

  // scan control
  assign scan_live = (state_q == ST_SCAN) && (idx_q < lim_q);
  assign hit       = scan_live && fit.fit;
  assign done      = (state_q == ST_SCAN) && (!scan_live || hit);
  assign out_free  = !out_valid_q || out_ready_i;
  assign commit    = done && out_free;
  assign advance   = scan_live && !hit;

  // next hole to fetch; hold the address while a result waits
  always_comb begin
    if (state_q == ST_IDLE) begin
      rd_cnt = '0;
    end else if (advance) begin
      rd_cnt = idx_q + 1'b1;
    end else begin
      rd_cnt = idx_q;
    end
  end

  assign rd_addr    = IdxW'(rd_cnt);
  assign rd_valid_d = (int'(rd_cnt) < HOLES) ? valid_q[rd_addr] : 1'b0;
  assign hole_val   = rd_valid_q ? ram_rdata : '0;

  // table write: a load, or the carved-down hole on a grant
  always_comb begin
    if (commit) begin
      wr_en   = hit;
      wr_addr = IdxW'(idx_q);
      wr_data = fit.rest;
    end else begin
      wr_en   = load_ok;
      wr_addr = IdxW'(slot_i);
      wr_data = amount_i;
    end
  end

  always_comb begin
    lim_d = lim_q;
    if (int'(hole_count_q) > HOLES) begin
      lim_d = CntW'(HOLES);
    end else begin
      lim_d = CntW'(hole_count_q);
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_alloc) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        if (commit) begin
          state_d = ST_IDLE;
        end else if (advance) begin
          idx_d = rd_cnt;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hole_count_q <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      lim_q        <= '0;
      rd_valid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      rd_valid_q <= rd_valid_d;
      if (cfg_we_i) begin
        hole_count_q <= cfg_wdata_i;
      end
      if (in_acc && is_alloc) begin
        lim_q <= lim_d;
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_alloc) begin
      req_q <= amount_i;
      tag_q <= tag_i;
    end
    if (commit) begin
      granted_q <= hit;
      chosen_q  <= hit ? ffha_pkg::SlotW'(idx_q) : '0;
      left_q    <= hit ? fit.rest : '0;
      tag_out_q <= tag_q;
    end
  end

  ffha_ram #(
    .Width (ffha_pkg::AmtW),
    .Depth (HOLES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  ffha_fit u_fit (
    .hole_i (hole_val),
    .req_i  (req_q),
    .res_o  (fit)
  );

  assign out_valid_o   = out_valid_q;
  assign granted_o     = granted_q;
  assign chosen_slot_o = chosen_q;
  assign left_over_o   = left_q;
  assign tag_out_o     = tag_out_q;

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= lim_q))
    else $error("scan index ran past the active hole count");

  a_grant_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_o) |-> (int'(chosen_slot_o) < int'(hole_count_q)))
    else $error("granted hole outside the searched range");

  a_refusal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> (chosen_slot_o == '0 && left_over_o == '0))
    else $error("refused result carries nonzero slot or size");

  a_result_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_SCAN))
    else $error("result registered outside a scan");
`endif

endmodule
